>>> rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants of the button gesture classifier
// Holds register layout, reset values, event codes and per-channel record.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int NUM_CHANNELS_DEF = 7;
	localparam int PIN_COUNT        = 7;
	localparam int APB_ADDR_W       = 5;
	localparam int APB_DATA_W       = 32;
	localparam int TIME_W           = 32;

	localparam logic [6:0]  LEVEL_MASK_RST = 7'h00;
	localparam logic [15:0] HOLD_MS_RST    = 16'd500;
	localparam logic [15:0] DOUBLE_MS_RST  = 16'd300;
	localparam logic [7:0]  DEBOUNCE_RST   = 8'd20;
	localparam logic [15:0] LONG_MS_RST    = 16'd500;

	typedef enum logic [2:0] {
		REG_LEVEL_MASK = 3'd0,
		REG_HOLD_MS    = 3'd1,
		REG_DOUBLE_MS  = 3'd2,
		REG_DEBOUNCE   = 3'd3,
		REG_LONG_MS    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_PRESS     = 3'd0,
		EV_SINGLE    = 3'd1,
		EV_DOUBLE    = 3'd2,
		EV_HOLD      = 3'd3,
		EV_LONG      = 3'd4,
		EV_LVL_HIGH  = 3'd5,
		EV_LVL_LOW   = 3'd6
	} event_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [6:0]  level_mask;
		logic [15:0] hold_ms;
		logic [15:0] double_ms;
		logic [7:0]  debounce_ms;
		logic [15:0] long_ms;
	} cfg_t;

	typedef struct packed {
		logic              prev_level;
		logic [TIME_W-1:0] press_time;
		logic [TIME_W-1:0] release_time;
		logic [TIME_W-1:0] held_length;
		logic              hold_reported;
		logic              click_pending;
	} chan_state_t;

	localparam int CHAN_STATE_W = $bits(chan_state_t);

	typedef struct packed {
		logic              vld;
		event_code_t       code;
		logic [TIME_W-1:0] dur;
	} event_t;

endpackage

>>> rtl/bgc_ifs.sv
// ----------------------------------------------------------------------------
// bgc_ifs: request channels of the button gesture classifier
// Tick channel carries pin levels in; event channel carries gestures out.
// ----------------------------------------------------------------------------
interface bgc_tick_if import bgc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIN_COUNT-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bgc_evt_if import bgc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        channel;
	logic [2:0]        event_code;
	logic [TIME_W-1:0] duration_ms;
	logic              last_event;

	modport source (output valid, output channel, output event_code, output duration_ms,
		output last_event, input ready);
	modport sink   (input valid, input channel, input event_code, input duration_ms,
		input last_event, output ready);
endinterface

>>> rtl/bgc_ram.sv
// ----------------------------------------------------------------------------
// bgc_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module bgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/bgc_regs.sv
// ----------------------------------------------------------------------------
// bgc_regs: configuration register file
// APB-style slave, zero wait states, five timing and mode registers.
// ----------------------------------------------------------------------------
module bgc_regs import bgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_go;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_go  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_mask  <= LEVEL_MASK_RST;
			cfg_q.hold_ms     <= HOLD_MS_RST;
			cfg_q.double_ms   <= DOUBLE_MS_RST;
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.long_ms     <= LONG_MS_RST;
		end else if (wr_go) begin
			case (idx)
				REG_LEVEL_MASK: cfg_q.level_mask  <= pwdata[6:0];
				REG_HOLD_MS:    cfg_q.hold_ms     <= pwdata[15:0];
				REG_DOUBLE_MS:  cfg_q.double_ms   <= pwdata[15:0];
				REG_DEBOUNCE:   cfg_q.debounce_ms <= pwdata[7:0];
				REG_LONG_MS:    cfg_q.long_ms     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LEVEL_MASK: prdata = {25'd0, cfg_q.level_mask};
			REG_HOLD_MS:    prdata = {16'd0, cfg_q.hold_ms};
			REG_DOUBLE_MS:  prdata = {16'd0, cfg_q.double_ms};
			REG_DEBOUNCE:   prdata = {24'd0, cfg_q.debounce_ms};
			REG_LONG_MS:    prdata = {16'd0, cfg_q.long_ms};
			default:        prdata = '0;
		endcase
	end

endmodule

>>> rtl/bgc_eval.sv
// ----------------------------------------------------------------------------
// bgc_eval: per-channel gesture update
// Takes one channel record and its pin, returns the new record and up to
// two events (edge or hold first, then click resolution).
// ----------------------------------------------------------------------------
module bgc_eval import bgc_pkg::*; (
	input  cfg_t              cfg,
	input  chan_state_t       st,
	input  logic              cur,
	input  logic              lvl,
	input  logic [TIME_W-1:0] now,
	output chan_state_t       st_n,
	output event_t            ev_a,
	output event_t            ev_b
);

	logic [TIME_W-1:0] dp;
	logic [TIME_W-1:0] dr;
	logic              chg;
	logic              skip;
	logic              btn_rel;

	assign dp   = now - st.press_time;
	assign dr   = now - st.release_time;
	assign chg  = cur != st.prev_level;
	assign skip = chg && (dp < TIME_W'(cfg.debounce_ms));

	always_comb begin
		st_n    = st;
		ev_a    = '0;
		ev_b    = '0;
		btn_rel = 1'b0;
		if (!skip) begin
			if (chg) begin
				ev_a.vld = 1'b1;
				if (cur) begin
					if (lvl) begin
						ev_a.code = EV_LVL_HIGH;
					end else begin
						ev_a.code       = EV_PRESS;
						st_n.press_time = now;
					end
				end else if (lvl) begin
					ev_a.code = EV_LVL_LOW;
				end else begin
					btn_rel          = 1'b1;
					st_n.held_length = dp;
					if ((dr < TIME_W'(cfg.double_ms)) && st.click_pending) begin
						ev_a.code          = EV_DOUBLE;
						st_n.click_pending = 1'b0;
					end else begin
						ev_a.vld           = 1'b0;
						st_n.click_pending = 1'b1;
					end
					st_n.release_time  = now;
					st_n.hold_reported = 1'b0;
				end
				st_n.prev_level = cur;
			end else if (cur && !st.hold_reported && !lvl && (dp > TIME_W'(cfg.hold_ms))) begin
				ev_a.vld           = 1'b1;
				ev_a.code          = EV_HOLD;
				st_n.hold_reported = 1'b1;
			end
			// a release in this visit restarts the gap at zero, never past the window
			if (st_n.click_pending && !btn_rel && (dr > TIME_W'(cfg.double_ms))) begin
				ev_b.vld = 1'b1;
				if (st.held_length < TIME_W'(cfg.long_ms)) begin
					ev_b.code = EV_SINGLE;
				end else begin
					ev_b.code = EV_LONG;
					ev_b.dur  = st.held_length;
				end
				st_n.click_pending = 1'b0;
			end
		end
	end

endmodule

>>> rtl/bgc_seq.sv
// ----------------------------------------------------------------------------
// bgc_seq: tick sequencer around the channel state memory
// Walks channels in order, read-modify-write of each record, and feeds the
// events through a one-deep hold slot so the final one of a tick is marked.
// ----------------------------------------------------------------------------
module bgc_seq import bgc_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	bgc_tick_if.sink  tick,
	bgc_evt_if.source evt
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	seq_state_t           state_q, state_n;
	logic [CH_W-1:0]      ch_q;
	logic [TIME_W-1:0]    clock_q;
	logic [PIN_COUNT-1:0] pins_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic                 rd_vld_q;
	event_t               ev_a_q, ev_b_q, pend_q;
	logic                 out_vld_q;
	logic [2:0]           out_ch_q;
	event_code_t          out_code_q;
	logic [TIME_W-1:0]    out_dur_q;
	logic                 out_last_q;
	logic [2:0]           pend_ch_q;

	logic                    accept;
	logic                    rd_en, wr_en;
	logic [CH_W-1:0]         rd_addr;
	logic [CHAN_STATE_W-1:0] rd_data;
	chan_state_t             st_rd, st_n;
	event_t                  ev_a, ev_b;
	logic [4:0]              ch_ext;
	logic                    cur, lvl;
	logic                    is_last, any_ev;
	logic                    out_free, stage_go, emit_done, flush_go, load_out;
	event_t                  stage_item;

	assign accept  = tick.valid && tick.ready;
	assign is_last = ch_q == LAST_CH;
	assign ch_ext  = 5'(ch_q);
	// channels past the pin count read as pressed and are never level mode
	assign cur = (ch_ext < 5'(PIN_COUNT)) ? ~pins_q[ch_ext[2:0]] : 1'b1;
	assign lvl = (ch_ext < 5'(PIN_COUNT)) && cfg.level_mask[ch_ext[2:0]];
	assign st_rd = rd_vld_q ? chan_state_t'(rd_data) : '0;
	assign any_ev = ev_a.vld || ev_b.vld;

	assign out_free   = !out_vld_q || evt.ready;
	assign stage_item = ev_a_q.vld ? ev_a_q : ev_b_q;
	assign stage_go   = !pend_q.vld || out_free;
	assign emit_done  = stage_go && !(ev_a_q.vld && ev_b_q.vld);
	assign flush_go   = !pend_q.vld || out_free;

	bgc_ram #(
		.WIDTH (CHAN_STATE_W),
		.DEPTH (NUM_CHANNELS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ch_q),
		.wr_data (CHAN_STATE_W'(st_n)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bgc_eval u_eval (
		.cfg  (cfg),
		.st   (st_rd),
		.cur  (cur),
		.lvl  (lvl),
		.now  (clock_q),
		.st_n (st_n),
		.ev_a (ev_a),
		.ev_b (ev_b)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_n = ST_EVAL;
			end
			ST_EVAL: begin
				if (any_ev) state_n = ST_EMIT;
				else if (is_last) state_n = ST_FLUSH;
			end
			ST_EMIT: begin
				if (emit_done) state_n = is_last ? ST_FLUSH : ST_EVAL;
			end
			ST_FLUSH: begin
				if (flush_go) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		tick.ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tick.ready = 1'b1;
				rd_en      = accept;
			end
			ST_EVAL: begin
				wr_en   = 1'b1;
				rd_en   = !is_last;
				rd_addr = ch_q + 1'b1;
			end
			ST_EMIT: begin
				load_out = stage_go && pend_q.vld;
			end
			ST_FLUSH: begin
				load_out = pend_q.vld && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= '0;
			clock_q   <= '0;
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			ev_a_q    <= '0;
			ev_b_q    <= '0;
			pend_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				clock_q <= clock_q + 1'b1;
				ch_q    <= '0;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[ch_q] <= 1'b1;
			end
			if (state_q == ST_EVAL) begin
				ev_a_q <= ev_a;
				ev_b_q <= ev_b;
				if (!any_ev && !is_last) ch_q <= ch_q + 1'b1;
			end
			if (state_q == ST_EMIT && stage_go) begin
				pend_q <= stage_item;
				if (ev_a_q.vld) ev_a_q.vld <= 1'b0;
				else ev_b_q.vld <= 1'b0;
				if (emit_done && !is_last) ch_q <= ch_q + 1'b1;
			end
			if (state_q == ST_FLUSH && flush_go) begin
				pend_q.vld <= 1'b0;
			end
			if (load_out) out_vld_q <= 1'b1;
			else if (evt.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pins_q <= tick.pin_levels;
		end
		if (state_q == ST_EMIT && stage_go) begin
			pend_ch_q <= ch_ext[2:0];
		end
		if (load_out) begin
			out_ch_q   <= pend_ch_q;
			out_code_q <= pend_q.code;
			out_dur_q  <= pend_q.dur;
			out_last_q <= state_q == ST_FLUSH;
		end
	end

	assign evt.valid       = out_vld_q;
	assign evt.channel     = out_ch_q;
	assign evt.event_code  = out_code_q;
	assign evt.duration_ms = out_dur_q;
	assign evt.last_event  = out_last_q;

endmodule

>>> rtl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier: seven-channel button gesture detector
// Classifies press, double press, hold, single click, long release and plain
// level changes from millisecond ticks of active-low pin levels.
// ----------------------------------------------------------------------------
// Each tick request carries one sample of the pins and advances a 32-bit
// millisecond clock that wraps. The block then visits the channels in order,
// reading each channel's record from a small state memory, updating it and
// writing it back, and sends one event request per gesture found; the last
// event of a tick has last_event set, and a tick that finds nothing sends
// nothing. A tick is taken in the idle state, each channel is evaluated in
// turn, each event passes through the emit state and a flush state closes
// the tick; an event sink that is not ready stalls the emit and flush
// states. Channels are walked one at a time through the single-read state
// memory. Ticks are taken one at a time; the event output register lets
// the next tick in while the last event still waits. The state memory needs
// no clearing pass: a per entry valid bit makes an unwritten record read as
// zero. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 and
// should be written only between ticks.
// ----------------------------------------------------------------------------
module button_gesture_classifier import bgc_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	bgc_tick_if.sink              tick,
	bgc_evt_if.source             evt
);

	cfg_t cfg;

	// register file: mode mask and the four time thresholds
	bgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// channel walk, state memory and event output stage
	bgc_seq #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.evt    (evt)
	);

endmodule
